FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every edge out of reset
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/pptl_pkg.sv
// ----------------------------------------------------------------------------
// pptl_pkg
// types and constants of the pps period tracking loop
// ----------------------------------------------------------------------------
`default_nettype none

package pptl_pkg;

    localparam int TIME_W  = 32;
    localparam int PHASE_W = 2;
    localparam int WIDE_W  = TIME_W + 2;

    localparam logic [TIME_W-1:0] TICKS_PER_SECOND = 32'd96000000;
    localparam logic [TIME_W-1:0] PERIOD_TOL       = TICKS_PER_SECOND / 32'd1000;
    localparam logic [TIME_W-1:0] DEBOUNCE_TICKS   = TICKS_PER_SECOND / 32'd4;
    localparam logic [TIME_W-1:0] PERIOD_LO        = TICKS_PER_SECOND - PERIOD_TOL;
    localparam logic [TIME_W-1:0] PERIOD_HI        = TICKS_PER_SECOND + PERIOD_TOL;

    localparam logic [PHASE_W-1:0] CODE_NONE   = 2'd0;
    localparam logic [PHASE_W-1:0] CODE_ONE    = 2'd1;
    localparam logic [PHASE_W-1:0] CODE_LOCKED = 2'd2;

    typedef enum logic [2:0] {
        PH_NONE   = 3'b001,
        PH_ONE    = 3'b010,
        PH_LOCKED = 3'b100
    } pptl_phase_t;

    typedef struct packed {
        pptl_phase_t       phase;
        logic [TIME_W-1:0] last_edge;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] last_error;
    } pptl_state_t;

    typedef struct packed {
        logic                     accepted;
        logic [PHASE_W-1:0]       lock_phase;
        logic [TIME_W-1:0]        period_ticks;
        logic signed [TIME_W-1:0] phase_error;
        logic                     error_valid;
        logic [TIME_W-1:0]        reference_time;
    } pptl_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/pptl_in_if.sv
// ----------------------------------------------------------------------------
// pptl_in_if
// capture item channel: action and timestamp with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface pptl_in_if
    import pptl_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic              action;
    logic [TIME_W-1:0] capture_time;

    modport source (output valid, output action, output capture_time, input ready);
    modport sink   (input valid, input action, input capture_time, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pptl_out_if.sv
// ----------------------------------------------------------------------------
// pptl_out_if
// result item channel: tracker status with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface pptl_out_if
    import pptl_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic [PHASE_W-1:0]       lock_phase;
    logic [TIME_W-1:0]        period_ticks;
    logic signed [TIME_W-1:0] phase_error;
    logic                     error_valid;
    logic [TIME_W-1:0]        reference_time;

    modport source (output valid, output accepted, output lock_phase, output period_ticks,
                    output phase_error, output error_valid, output reference_time,
                    input ready);
    modport sink   (input valid, input accepted, input lock_phase, input period_ticks,
                    input phase_error, input error_valid, input reference_time,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pps_period_tracking_loop_unit.sv
// ----------------------------------------------------------------------------
// pps_period_tracking_loop_unit
// tracks the period of a pulse-per-second input in clock ticks
//
// sample carries one capture item: action 0 is an edge with its timestamp,
// action 1 restarts the loop from the first edge. result returns one item
// per capture: whether the edge was used, the lock phase, the tracked
// period, the phase error of the last tracked edge and the reference time.
// an item is registered on entry and its result is registered in the output
// register once that register is empty or being taken; one item is taken
// every cycle while result is not stalled, as the tracker state is updated in
// a single pass of the update logic between those registers.
// when result is stalled the finished item waits in the output register
// and sample still takes one more item into the input register; after that
// sample.ready drops until the output is taken.
// reset clears the valid flags of both registers and returns the tracker to no
// edge seen with the nominal period; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pps_period_tracking_loop_unit
    import pptl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    pptl_in_if.sink    sample,
    pptl_out_if.source result
);

    logic              in_valid_reg;
    logic              in_action_reg;
    logic [TIME_W-1:0] in_time_reg;
    logic              out_valid_reg;
    pptl_result_t      res_reg;
    pptl_result_t      res_next;
    pptl_state_t       state_reg;
    pptl_state_t       state_next;
    logic              advance;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;

    pptl_update u_update (
        .state        (state_reg),
        .action       (in_action_reg),
        .capture_time (in_time_reg),
        .state_next   (state_next),
        .res          (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.phase       <= PH_NONE;
            state_reg.last_edge   <= '0;
            state_reg.period      <= TICKS_PER_SECOND;
            state_reg.last_error  <= '0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_action_reg <= sample.action;
            in_time_reg   <= sample.capture_time;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.accepted       = res_reg.accepted;
    assign result.lock_phase     = res_reg.lock_phase;
    assign result.period_ticks   = res_reg.period_ticks;
    assign result.phase_error    = res_reg.phase_error;
    assign result.error_valid    = res_reg.error_valid;
    assign result.reference_time = res_reg.reference_time;

    `ASSERT_ALWAYS(a_period_in_range, (state_reg.period >= PERIOD_LO) && (state_reg.period <= PERIOD_HI))
    `ASSERT_NEXT(a_relock_unlocks, advance && in_action_reg, (state_reg.phase == PH_NONE) && !res_reg.accepted)
    `ASSERT_SAME(a_error_valid_locked, out_valid_reg, res_reg.error_valid == (res_reg.lock_phase == CODE_LOCKED))
    `ASSERT_SAME(a_no_error_unlocked, out_valid_reg && !res_reg.error_valid, res_reg.phase_error == '0)

endmodule

`default_nettype wire

FILE: rtl/core/pptl_update.sv
// ----------------------------------------------------------------------------
// pptl_update
// per-item tracker update: relock, debounce, phase error, correction and clamp
// ----------------------------------------------------------------------------
`default_nettype none

module pptl_update
    import pptl_pkg::*;
(
    input  pptl_state_t       state,
    input  logic              action,
    input  logic [TIME_W-1:0] capture_time,
    output pptl_state_t       state_next,
    output pptl_result_t      res
);

    function automatic logic [TIME_W-1:0] clamp_period(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] hi;
        lo = $signed({2'b00, PERIOD_LO});
        hi = $signed({2'b00, PERIOD_HI});
        if (v < lo)
        begin
            return PERIOD_LO;
        end
        else if (v > hi)
        begin
            return PERIOD_HI;
        end
        return v[TIME_W-1:0];
    endfunction

    function automatic logic [PHASE_W-1:0] phase_code(input pptl_phase_t ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_NONE:   code = CODE_NONE;
            PH_ONE:    code = CODE_ONE;
            PH_LOCKED: code = CODE_LOCKED;
            default:   code = CODE_LOCKED;
        endcase
        return code;
    endfunction

    localparam logic signed [WIDE_W-1:0] TOL_S = $signed({2'b00, PERIOD_TOL});

    logic [TIME_W-1:0]        since_edge;
    logic                     bounce;
    logic [TIME_W-1:0]        raw_err;
    logic signed [WIDE_W-1:0] err_w;
    logic signed [WIDE_W-1:0] err_c;
    logic signed [WIDE_W-1:0] corr;
    logic signed [WIDE_W-1:0] new_period;
    logic                     locked_next;

    always_comb
    begin
        since_edge = capture_time - state.last_edge;
        bounce     = (state.phase != PH_NONE) && (since_edge < DEBOUNCE_TICKS);
        raw_err    = capture_time - state.last_edge - state.period;
        err_w      = $signed({{2{raw_err[TIME_W-1]}}, raw_err});

        if (err_w > TOL_S)
        begin
            err_c = TOL_S;
        end
        else if (err_w < -TOL_S)
        begin
            err_c = -TOL_S;
        end
        else
        begin
            err_c = err_w;
        end

        if (err_c[WIDE_W-1])
        begin
            corr = (err_c + WIDE_W'(3)) >>> 2;
        end
        else
        begin
            corr = err_c >>> 2;
        end
        if ((corr == '0) && (err_c != '0))
        begin
            corr = err_c[WIDE_W-1] ? -WIDE_W'(1) : WIDE_W'(1);
        end
        new_period = $signed({2'b00, state.period}) + corr;

        state_next   = state;
        res.accepted = 1'b0;
        priority if (action)
        begin
            state_next.phase      = PH_NONE;
            state_next.last_error = '0;
        end
        else if (bounce)
        begin
            state_next = state;
        end
        else
        begin
            res.accepted = 1'b1;
            unique case (state.phase)
                PH_NONE:
                begin
                    state_next.phase      = PH_ONE;
                    state_next.last_edge  = capture_time;
                    state_next.last_error = '0;
                    state_next.period     = clamp_period($signed({2'b00, state.period}));
                end
                PH_ONE:
                begin
                    state_next.phase      = PH_LOCKED;
                    state_next.last_edge  = capture_time;
                    state_next.last_error = '0;
                    state_next.period     = clamp_period($signed({2'b00, since_edge}));
                end
                default:
                begin
                    state_next.phase      = PH_LOCKED;
                    state_next.last_edge  = capture_time;
                    state_next.last_error = raw_err;
                    state_next.period     = clamp_period(new_period);
                end
            endcase
        end

        locked_next        = (state_next.phase == PH_LOCKED);
        res.lock_phase     = phase_code(state_next.phase);
        res.period_ticks   = state_next.period;
        res.phase_error    = locked_next ? $signed(state_next.last_error) : '0;
        res.error_valid    = locked_next;
        res.reference_time = state_next.last_edge;
    end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression for the pps period tracking loop. A short table of edge and
// relock items walks lock-up, bounce rejection, correction limits, period
// clamps and timestamp wrap. A long run of captures near the tracked period
// follows, mixed with bounces, stray timestamps and relocks. An in-bench
// tracker predicts each untyped result item, typed table rows carry their own,
// and the results are compared in order, field by field. Both channels idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top
    import pptl_pkg::*;
    ;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_EDGE   = 1'b0;
    localparam logic ACT_RELOCK = 1'b1;

    localparam int N_DIRECTED   = 25;
    localparam int RANDOM_STAGE = 550;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [1:0] {AT_ABS, AT_EDGE, AT_EXPECTED} stamp_base_t;

    typedef struct {
        logic         act;
        stamp_base_t  base;
        logic [31:0]  offset;
        bit           typed;
        pptl_result_t want;
    } capture_row_t;

    localparam pptl_result_t NO_WANT = '0;

    capture_row_t directed_rows [N_DIRECTED] = '{
        '{ACT_EDGE,   AT_ABS,      32'd0,                    1'b1,
          '{1'b1, CODE_ONE, TICKS_PER_SECOND, 32'sd0, 1'b0, 32'd0}},
        '{ACT_EDGE,   AT_EDGE,     DEBOUNCE_TICKS - 32'd1,   1'b1,
          '{1'b0, CODE_ONE, TICKS_PER_SECOND, 32'sd0, 1'b0, 32'd0}},
        '{ACT_EDGE,   AT_EDGE,     DEBOUNCE_TICKS,           1'b1,
          '{1'b1, CODE_LOCKED, PERIOD_LO, 32'sd0, 1'b1, DEBOUNCE_TICKS}},
        '{ACT_EDGE,   AT_EXPECTED, 32'd1,                    1'b0, NO_WANT},
        '{ACT_EDGE,   AT_EXPECTED, -32'd3,                   1'b0, NO_WANT},
        '{ACT_EDGE,   AT_EDGE,     DEBOUNCE_TICKS - 32'd1,   1'b0, NO_WANT},
        '{ACT_EDGE,   AT_EXPECTED, 32'h7FFF_FFFF,            1'b0, NO_WANT},
        '{ACT_EDGE,   AT_EXPECTED, 32'h8000_0000,            1'b0, NO_WANT},
        '{ACT_EDGE,   AT_EXPECTED, 32'd4,                    1'b0, NO_WANT},
        '{ACT_EDGE,   AT_EXPECTED, -32'd7,                   1'b0, NO_WANT},
        '{ACT_EDGE,   AT_EXPECTED, PERIOD_TOL,               1'b0, NO_WANT},
        '{ACT_EDGE,   AT_EXPECTED, -(PERIOD_TOL + 32'd1),    1'b0, NO_WANT},
        '{ACT_EDGE,   AT_EXPECTED, 32'd0,                    1'b0, NO_WANT},
        '{ACT_RELOCK, AT_ABS,      32'hFFFF_FFFF,            1'b0, NO_WANT},
        '{ACT_RELOCK, AT_ABS,      32'd0,                    1'b0, NO_WANT},
        '{ACT_EDGE,   AT_ABS,      32'hFFFF_FFFF,            1'b0, NO_WANT},
        '{ACT_EDGE,   AT_EDGE,     TICKS_PER_SECOND,         1'b1,
          '{1'b1, CODE_LOCKED, TICKS_PER_SECOND, 32'sd0, 1'b1, TICKS_PER_SECOND - 32'd1}},
        '{ACT_EDGE,   AT_EDGE,     32'hFFFF_FFFF,            1'b0, NO_WANT},
        '{ACT_RELOCK, AT_ABS,      32'h5A5A_5A5A,            1'b0, NO_WANT},
        '{ACT_EDGE,   AT_ABS,      32'h8000_0000,            1'b0, NO_WANT},
        '{ACT_RELOCK, AT_ABS,      32'd0,                    1'b0, NO_WANT},
        '{ACT_EDGE,   AT_ABS,      32'h8000_0000,            1'b0, NO_WANT},
        '{ACT_EDGE,   AT_EDGE,     32'hFFFF_FFFF,            1'b1,
          '{1'b1, CODE_LOCKED, PERIOD_HI, 32'sd0, 1'b1, 32'h7FFF_FFFF}},
        '{ACT_EDGE,   AT_EDGE,     32'd0,                    1'b1,
          '{1'b0, CODE_LOCKED, PERIOD_HI, 32'sd0, 1'b1, 32'h7FFF_FFFF}},
        '{ACT_EDGE,   AT_EXPECTED, 32'hFFFF_FFFF,            1'b0, NO_WANT}
    };

    logic clk;
    logic rst_n;

    pptl_in_if  sample_if ();
    pptl_out_if result_if ();

    pps_period_tracking_loop_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if)
    );

    logic [PHASE_W-1:0] trk_phase;
    logic [TIME_W-1:0]  trk_edge;
    logic [TIME_W-1:0]  trk_period;
    logic [TIME_W-1:0]  trk_error;

    pptl_result_t expected_status [$];
    pptl_result_t oldest;

    int errors;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_kick;

    always #5 clk = ~clk;

    function automatic pptl_result_t track_edge(input logic act, input logic [31:0] stamp);
        pptl_result_t r;
        logic [31:0]  since;
        logic [31:0]  raw;
        longint       err;
        longint       tol;
        longint       step;
        longint       np;
        logic         took;
        took = 1'b0;
        tol = longint'(PERIOD_TOL);
        since = stamp - trk_edge;
        if (trk_phase > CODE_LOCKED)
            trk_phase = CODE_LOCKED;
        if (act == ACT_RELOCK)
        begin
            trk_phase = CODE_NONE;
            trk_error = '0;
        end
        else if (trk_phase != CODE_NONE && since < DEBOUNCE_TICKS)
        begin
            took = 1'b0;
        end
        else
        begin
            took = 1'b1;
            if (trk_phase == CODE_NONE)
            begin
                trk_edge  = stamp;
                trk_error = '0;
                trk_phase = CODE_ONE;
            end
            else if (trk_phase == CODE_ONE)
            begin
                trk_period = since;
                trk_error  = '0;
                trk_edge   = stamp;
                trk_phase  = CODE_LOCKED;
            end
            else
            begin
                raw = stamp - (trk_edge + trk_period);
                trk_error = raw;
                err = longint'($signed(raw));
                if (err > tol)
                    err = tol;
                else if (err < -tol)
                    err = -tol;
                step = err / 4;
                if (step == 0 && err != 0)
                    step = (err > 0) ? 1 : -1;
                np = longint'(trk_period) + step;
                if (np < 0)
                    np = 0;
                if (np > 64'sh0000_0000_FFFF_FFFF)
                    np = 64'sh0000_0000_FFFF_FFFF;
                trk_period = np[31:0];
                trk_edge = stamp;
            end
            if (trk_period < PERIOD_LO)
                trk_period = PERIOD_LO;
            else if (trk_period > PERIOD_HI)
                trk_period = PERIOD_HI;
        end
        r.accepted       = took;
        r.lock_phase     = trk_phase;
        r.period_ticks   = trk_period;
        r.error_valid    = (trk_phase == CODE_LOCKED);
        r.phase_error    = r.error_valid ? trk_error : '0;
        r.reference_time = trk_edge;
        return r;
    endfunction

    task automatic offer_capture(input logic act, input logic [31:0] stamp,
                                 input bit typed, input pptl_result_t want);
        pptl_result_t got;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid        <= 1'b1;
        sample_if.action       <= act;
        sample_if.capture_time <= stamp;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
        got = track_edge(act, stamp);
        expected_status.push_back(typed ? want : got);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
        end
    endtask

    initial
    begin
        int          pick;
        int          off;
        logic        act;
        logic [31:0] stamp;
        clk = 1'b0;
        rst_n = 1'b0;
        sample_if.valid = 1'b0;
        sample_if.action = ACT_EDGE;
        sample_if.capture_time = '0;
        trk_phase = CODE_NONE;
        trk_edge = '0;
        trk_period = TICKS_PER_SECOND;
        trk_error = '0;
        errors = 0;
        hold_kick = 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 48;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].base)
                AT_ABS:  stamp = directed_rows[i].offset;
                AT_EDGE: stamp = trk_edge + directed_rows[i].offset;
                default: stamp = trk_edge + trk_period + directed_rows[i].offset;
            endcase
            offer_capture(directed_rows[i].act, stamp, directed_rows[i].typed,
                          directed_rows[i].want);
        end

        for (int stage = 0; stage < 3; stage++)
        begin
            case (stage)
                0:
                begin
                    send_idle_pct = 30;
                    recv_idle_pct = 48;
                end
                1:
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 30;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_kick = 1'b1;
                end
            endcase
            repeat (RANDOM_STAGE)
            begin
                pick = $urandom_range(0, 99);
                act = ACT_EDGE;
                if (pick < 3)
                begin
                    act = ACT_RELOCK;
                    stamp = $urandom;
                end
                else if (pick < 8)
                    stamp = $urandom;
                else if (pick < 15)
                    stamp = trk_edge + $urandom_range(0, DEBOUNCE_TICKS - 1);
                else if (pick < 20)
                    stamp = trk_edge + DEBOUNCE_TICKS - $urandom_range(0, 1);
                else if (pick < 28)
                    stamp = trk_edge + trk_period + $urandom;
                else if (pick < 45)
                begin
                    off = $urandom_range(0, 16);
                    stamp = trk_edge + trk_period + off - 32'd8;
                end
                else
                begin
                    off = $urandom_range(0, 4 * PERIOD_TOL);
                    stamp = trk_edge + trk_period + off - 2 * PERIOD_TOL;
                end
                offer_capture(act, stamp, 1'b0, NO_WANT);
            end
        end
        sample_if.valid <= 1'b0;

        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("pps_period_tracking_loop_unit regression: pass");
        else
            $display("pps_period_tracking_loop_unit regression: fail");
        $finish;
    end

    // result side: random back-pressure plus one long hold-off
    initial
    begin
        hold_left = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_kick)
            begin
                hold_kick = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_status.size() == 0)
            begin
                errors++;
                $display("%0t ns: result item with nothing expected", $time);
            end
            else
            begin
                oldest = expected_status.pop_front();
                check_field("accepted", 32'(oldest.accepted), 32'(result_if.accepted));
                check_field("lock_phase", 32'(oldest.lock_phase),
                            32'(result_if.lock_phase));
                check_field("period_ticks", oldest.period_ticks, result_if.period_ticks);
                check_field("phase_error", oldest.phase_error, result_if.phase_error);
                check_field("error_valid", 32'(oldest.error_valid),
                            32'(result_if.error_valid));
                check_field("reference_time", oldest.reference_time,
                            result_if.reference_time);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("%0t ns: cycle limit reached", $time);
                $display("pps_period_tracking_loop_unit regression: fail");
                $finish;
            end
        end
    end

endmodule
